// ----- design/can_acceptance_filter_table_macros.svh -----
// Assertion macros used by the checker of the CAN acceptance filter table.
// No dependencies; take in with `include by bare file name.
`ifndef CAN_ACCEPTANCE_FILTER_TABLE_MACROS_SVH
`define CAN_ACCEPTANCE_FILTER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of the given clock.
`define CAFT_ASSERT_IMPL(label, clock, dis, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising edge of the given clock.
`define CAFT_ASSERT_NEXT(label, clock, dis, ante, cons, msg) \
  label: assert property (@(posedge clock) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/caft_pkg.sv -----
// Types and constants of the CAN acceptance filter table.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package caft_pkg;

  localparam int ID_W       = 29;
  localparam int STD_ID_W   = 11;
  localparam int SLOT_W     = 3;
  localparam int INDEX_W    = 4;
  localparam int MAX_HITS   = 8;
  localparam int HIT_CNT_W  = $clog2(MAX_HITS + 1);
  // Depth of the command queue between front and back; must be a power of two.
  localparam int CMDQ_DEPTH = 4;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_MATCH  = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_ADDED   = 2'd0,
    ST_NOSPACE = 2'd1,
    ST_INVALID = 2'd2,
    ST_HIT     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CMD_ADD,
    CMD_INVALID,
    CMD_REMOVE,
    CMD_MATCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [ID_W-1:0]    ident;
    logic [ID_W-1:0]    id_mask;
    logic               extended;
    logic [INDEX_W-1:0] index;
  } cmd_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic               last_hit;
  } res_t;

endpackage

// ----- design/caft_front.sv -----
// Front end: accepts items, checks filter widths and turns them into commands.
// Depends on caft_pkg.
`timescale 1ns / 1ps

module caft_front #(
  parameter int FILTER_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    opcode,
  input  logic [caft_pkg::ID_W-1:0]     ident,
  input  logic [caft_pkg::ID_W-1:0]     id_mask,
  input  logic                          extended,
  input  logic [caft_pkg::INDEX_W-1:0]  slot_index,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output caft_pkg::cmd_t                cmd
);

  logic           accept;
  logic           keep;
  logic           too_wide;
  caft_pkg::cmd_t cmd_next;

  assign full   = cmd_valid && !cmd_ready;
  assign accept = push && !full;

  // A standard filter may use only the low eleven bits of ident and mask.
  assign too_wide = !extended &&
                    ((ident[caft_pkg::ID_W-1:caft_pkg::STD_ID_W] != '0) ||
                     (id_mask[caft_pkg::ID_W-1:caft_pkg::STD_ID_W] != '0));

  always_comb begin
    cmd_next.ident    = ident;
    cmd_next.id_mask  = id_mask;
    cmd_next.extended = extended;
    cmd_next.index    = slot_index;
    cmd_next.kind     = caft_pkg::CMD_MATCH;
    keep              = 1'b0;
    case (opcode)
      caft_pkg::OP_ADD: begin
        cmd_next.kind = too_wide ? caft_pkg::CMD_INVALID : caft_pkg::CMD_ADD;
        keep          = 1'b1;
      end
      caft_pkg::OP_REMOVE: begin
        cmd_next.kind = caft_pkg::CMD_REMOVE;
        keep          = 32'(slot_index) < 32'(FILTER_SLOTS);
      end
      caft_pkg::OP_MATCH: begin
        cmd_next.kind = caft_pkg::CMD_MATCH;
        keep          = 1'b1;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (accept) begin
      cmd_valid <= keep;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd <= cmd_next;
    end
  end

endmodule

// ----- design/caft_queue.sv -----
// Short command queue that decouples the front end from the table engine.
// Depends on caft_pkg.
`timescale 1ns / 1ps

module caft_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  caft_pkg::cmd_t wr_data,
  output logic           rd_valid,
  input  logic           rd_pop,
  output caft_pkg::cmd_t rd_data
);

  localparam int DEPTH = caft_pkg::CMDQ_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);

  caft_pkg::cmd_t   entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = count != (PTR_W + 1)'(DEPTH);
  assign rd_valid = count != '0;
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_pop && rd_valid;
  assign rd_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wr_ptr] <= wr_data;
    end
  end

endmodule

// ----- design/caft_back.sv -----
// Table engine: holds the filters, executes commands and drives the result register.
// Depends on caft_pkg.
`timescale 1ns / 1ps

module caft_back #(
  parameter int FILTER_SLOTS = 8
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_pop,
  input  caft_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_pop,
  output caft_pkg::res_t res
);

  localparam int IDX_W  = (FILTER_SLOTS > 1) ? $clog2(FILTER_SLOTS) : 1;
  localparam int SLOT_W = caft_pkg::SLOT_W;
  localparam int CNT_W  = caft_pkg::HIT_CNT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FLUSH
  } state_t;

  state_t                    state;
  logic [FILTER_SLOTS-1:0]   active;
  logic [caft_pkg::ID_W-1:0] tbl_ident [FILTER_SLOTS];
  logic [caft_pkg::ID_W-1:0] tbl_mask  [FILTER_SLOTS];
  logic                      tbl_ext   [FILTER_SLOTS];

  logic [caft_pkg::ID_W-1:0] frame_id;
  logic                      frame_ext;
  logic [IDX_W-1:0]          scan_idx;
  logic [IDX_W-1:0]          pend_slot;
  logic                      pend_valid;
  logic [CNT_W-1:0]          hit_count;

  logic                      out_free;
  logic                      free_found;
  logic [IDX_W-1:0]          free_idx;
  logic [IDX_W-1:0]          rm_idx;
  logic                      hit;
  logic                      scan_last;
  logic [CNT_W-1:0]          count_next;

  assign out_free   = !res_valid || res_pop;
  assign rm_idx     = IDX_W'(cmd.index);
  assign scan_last  = scan_idx == IDX_W'(FILTER_SLOTS - 1);
  assign count_next = hit_count + 1'b1;
  assign hit        = active[scan_idx] && (tbl_ext[scan_idx] == frame_ext) &&
                      (((frame_id ^ tbl_ident[scan_idx]) & tbl_mask[scan_idx]) == '0);

  // Lowest free slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = FILTER_SLOTS - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    cmd_pop = 1'b0;
    if (state == S_IDLE && cmd_valid) begin
      case (cmd.kind)
        caft_pkg::CMD_REMOVE,
        caft_pkg::CMD_MATCH: cmd_pop = 1'b1;
        default:             cmd_pop = out_free;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      active     <= '0;
      res_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (res_pop) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            case (cmd.kind)
              caft_pkg::CMD_ADD: begin
                if (out_free) begin
                  res_valid    <= 1'b1;
                  res.last_hit <= 1'b1;
                  if (free_found) begin
                    active[free_idx]    <= 1'b1;
                    tbl_ident[free_idx] <= cmd.ident;
                    tbl_mask[free_idx]  <= cmd.id_mask;
                    tbl_ext[free_idx]   <= cmd.extended;
                    res.status          <= caft_pkg::ST_ADDED;
                    res.slot            <= SLOT_W'(free_idx);
                  end else begin
                    res.status <= caft_pkg::ST_NOSPACE;
                    res.slot   <= '0;
                  end
                end
              end
              caft_pkg::CMD_INVALID: begin
                if (out_free) begin
                  res_valid    <= 1'b1;
                  res.status   <= caft_pkg::ST_INVALID;
                  res.slot     <= '0;
                  res.last_hit <= 1'b1;
                end
              end
              caft_pkg::CMD_REMOVE: begin
                active[rm_idx] <= 1'b0;
              end
              caft_pkg::CMD_MATCH: begin
                frame_id   <= cmd.ident;
                frame_ext  <= cmd.extended;
                scan_idx   <= '0;
                hit_count  <= '0;
                pend_valid <= 1'b0;
                state      <= S_SCAN;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (hit) begin
            // A new hit releases the previous one, which is then known not to be last.
            if (!pend_valid || out_free) begin
              if (pend_valid) begin
                res_valid    <= 1'b1;
                res.status   <= caft_pkg::ST_HIT;
                res.slot     <= SLOT_W'(pend_slot);
                res.last_hit <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_slot  <= scan_idx;
              hit_count  <= count_next;
              if (scan_last || count_next == CNT_W'(caft_pkg::MAX_HITS)) begin
                state <= S_FLUSH;
              end else begin
                scan_idx <= scan_idx + 1'b1;
              end
            end
          end else if (scan_last) begin
            state <= pend_valid ? S_FLUSH : S_IDLE;
          end else begin
            scan_idx <= scan_idx + 1'b1;
          end
        end
        S_FLUSH: begin
          if (out_free) begin
            res_valid    <= 1'b1;
            res.status   <= caft_pkg::ST_HIT;
            res.slot     <= SLOT_W'(pend_slot);
            res.last_hit <= 1'b1;
            pend_valid   <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- design/can_acceptance_filter_table.sv -----
// Top level of the CAN acceptance filter table: front end, command queue, table engine.
// Depends on caft_pkg, caft_front, caft_queue and caft_back.
`timescale 1ns / 1ps

// The block keeps FILTER_SLOTS acceptance filters and takes one command per item on a
// queue-style port (push/full). An add command stores an identifier, a mask and the
// extended flag in the lowest free slot and reports that slot; it reports no-space when
// every slot is in use, and invalid when a standard filter uses bits above the eleventh.
// A remove command frees a slot and produces nothing; an index beyond the table is
// ignored, as is the unused opcode. A match command compares the frame identifier with
// every active slot of the same kind, lowest slot first, and reports one hit per slot
// whose masked bits agree; the final hit of a frame carries last_hit, at most eight hits
// are reported, and a frame that matches nothing produces no result. Results leave
// through a one-entry output register (empty/pop); items keep being taken into the
// command queue while a result waits there, until that queue is full. An item passes
// a classification register and a four-entry command queue before the table engine
// sees it. Add and remove are handled in the idle state, an add waiting there until
// the output register is free. A match moves into a scan state, in which one
// comparator visits one slot per cycle, lowest first, but a new hit waits while the
// previous hit cannot yet enter the output register; the scan ends at the last slot
// or at the eighth hit, and a flush state then releases any final hit. Reset is
// synchronous and clears all slots at once; no clearing pass is needed.
module can_acceptance_filter_table #(
  parameter int FILTER_SLOTS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic [1:0]                    opcode,
  input  logic [caft_pkg::ID_W-1:0]     ident,
  input  logic [caft_pkg::ID_W-1:0]     id_mask,
  input  logic                          extended,
  input  logic [caft_pkg::INDEX_W-1:0]  slot_index,
  output logic                          empty,
  input  logic                          pop,
  output logic [1:0]                    status,
  output logic [caft_pkg::SLOT_W-1:0]   slot,
  output logic                          last_hit
);

  // Front end to command queue.
  logic           f_valid;
  logic           f_ready;
  caft_pkg::cmd_t f_cmd;

  // Command queue to table engine.
  logic           q_valid;
  logic           q_pop;
  caft_pkg::cmd_t q_cmd;

  // Result register.
  logic           res_valid;
  logic           res_pop;
  caft_pkg::res_t res;

  caft_front #(
    .FILTER_SLOTS (FILTER_SLOTS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .opcode     (opcode),
    .ident      (ident),
    .id_mask    (id_mask),
    .extended   (extended),
    .slot_index (slot_index),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  caft_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (q_valid),
    .rd_pop   (q_pop),
    .rd_data  (q_cmd)
  );

  caft_back #(
    .FILTER_SLOTS (FILTER_SLOTS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_pop   (q_pop),
    .cmd       (q_cmd),
    .res_valid (res_valid),
    .res_pop   (res_pop),
    .res       (res)
  );

  // The output register is the head of the result queue seen by the consumer.
  assign empty    = !res_valid;
  assign res_pop  = pop && res_valid;
  assign status   = res.status;
  assign slot     = res.slot;
  assign last_hit = res.last_hit;

endmodule

// ----- design/caft_checker.sv -----
// Port-level checker for the CAN acceptance filter table, bound to the top level.
// Depends on caft_pkg and can_acceptance_filter_table_macros.svh.
`timescale 1ns / 1ps
`include "can_acceptance_filter_table_macros.svh"

module caft_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        empty,
  input logic                        pop,
  input logic [1:0]                  status,
  input logic [caft_pkg::SLOT_W-1:0] slot,
  input logic                        last_hit
);

  // Nothing is offered to the consumer straight after reset.
  `CAFT_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, empty, "result offered after reset")

  // Add results are always the only result of their item.
  `CAFT_ASSERT_IMPL(a_add_last, clk, rst, !empty && status != caft_pkg::ST_HIT, last_hit, "add result without last_hit")

  // Failed adds report slot zero.
  `CAFT_ASSERT_IMPL(a_fail_slot, clk, rst, !empty && (status == caft_pkg::ST_NOSPACE || status == caft_pkg::ST_INVALID), slot == '0, "failed add reports a slot")

  // A result that is not taken stays as it is.
  `CAFT_ASSERT_NEXT(a_hold, clk, rst, !empty && !pop, !empty && $stable(status) && $stable(slot) && $stable(last_hit), "waiting result changed")

endmodule

bind can_acceptance_filter_table caft_checker u_caft_checker (.*);

// ----- tb/testbench.sv -----
// Self-checking testbench for the CAN acceptance filter table (can_acceptance_filter_table).
// Depends on caft_pkg and the RTL of the block; a scoreboard class predicts every result item.
`timescale 1ns / 1ps

module testbench;

  typedef logic [caft_pkg::ID_W-1:0]    ident_t;
  typedef logic [caft_pkg::INDEX_W-1:0] index_t;

  localparam int FILTER_SLOTS = 8;
  // The block ignores opcode 3. The package has no name for it, so it is named here.
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam ident_t STD_LIMIT = 29'h7FF;
  localparam ident_t EXT_LIMIT = 29'h1FFF_FFFF;
  localparam int RANDOM_ITEMS = 500;
  localparam int HOLD_CYCLES = 300;

  // The filter table predictor and the queue of result items still owed by the block.
  // The table copy is also read by the stimulus, so that frames can be aimed at live filters.
  class filter_scoreboard;
    bit                filter_active[FILTER_SLOTS];
    ident_t            filter_ident[FILTER_SLOTS];
    ident_t            filter_mask[FILTER_SLOTS];
    bit                filter_ext[FILTER_SLOTS];
    caft_pkg::res_t    owed_results[$];
    int                errors;

    function new();
      errors = 0;
      foreach (filter_active[i]) filter_active[i] = 1'b0;
    endfunction

    function int used_slots();
      int n;
      n = 0;
      foreach (filter_active[i]) if (filter_active[i]) n++;
      return n;
    endfunction

    // Picks one active slot at random; only called when at least one slot is in use.
    function int random_active_slot();
      int live[$];
      foreach (filter_active[i]) if (filter_active[i]) live.push_back(i);
      return live[$urandom_range(0, live.size() - 1)];
    endfunction

    function int outstanding();
      return owed_results.size();
    endfunction

    // Updates the table copy for one accepted item and queues the result items it causes.
    function void note_item(logic [1:0] op, ident_t id, ident_t msk, bit ext, index_t idx);
      caft_pkg::res_t r;
      ident_t limit;
      int hits;
      bit placed;
      hits = 0;
      placed = 1'b0;
      case (op)
        caft_pkg::OP_ADD: begin
          limit = ext ? EXT_LIMIT : STD_LIMIT;
          r.last_hit = 1'b1;
          r.slot = '0;
          if (id > limit || msk > limit) begin
            r.status = caft_pkg::ST_INVALID;
          end else begin
            r.status = caft_pkg::ST_NOSPACE;
            for (int i = 0; i < FILTER_SLOTS && !placed; i++) begin
              if (!filter_active[i]) begin
                filter_active[i] = 1'b1;
                filter_ident[i] = id;
                filter_mask[i] = msk;
                filter_ext[i] = ext;
                r.status = caft_pkg::ST_ADDED;
                r.slot = i[caft_pkg::SLOT_W-1:0];
                placed = 1'b1;
              end
            end
          end
          owed_results.push_back(r);
        end
        caft_pkg::OP_REMOVE: begin
          if (idx < FILTER_SLOTS) filter_active[idx] = 1'b0;
        end
        caft_pkg::OP_MATCH: begin
          for (int i = 0; i < FILTER_SLOTS && hits < caft_pkg::MAX_HITS; i++) begin
            if (filter_active[i] && filter_ext[i] == ext &&
                ((id ^ filter_ident[i]) & filter_mask[i]) == '0) begin
              r.status = caft_pkg::ST_HIT;
              r.slot = i[caft_pkg::SLOT_W-1:0];
              r.last_hit = 1'b0;
              owed_results.push_back(r);
              hits++;
            end
          end
          // Only the final hit of a frame carries the last-hit flag.
          if (hits > 0) owed_results[owed_results.size() - 1].last_hit = 1'b1;
        end
        default: ;
      endcase
    endfunction

    // Compares one accepted result item with the oldest prediction.
    function void check_result(logic [1:0] got_status, logic [caft_pkg::SLOT_W-1:0] got_slot,
                               logic got_last);
      caft_pkg::res_t want;
      if (owed_results.size() == 0) begin
        $error("unexpected result item: status %0d slot %0d last_hit %0d",
               got_status, got_slot, got_last);
        errors++;
        return;
      end
      want = owed_results.pop_front();
      if (got_status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got_status);
        errors++;
      end
      if (got_slot !== want.slot) begin
        $error("slot: expected %0d, actual %0d", want.slot, got_slot);
        errors++;
      end
      if (got_last !== want.last_hit) begin
        $error("last_hit: expected %0d, actual %0d", want.last_hit, got_last);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic [1:0]                    opcode;
  ident_t                        ident;
  ident_t                        id_mask;
  logic                          extended;
  index_t                        slot_index;
  logic                          empty;
  logic                          pop;
  logic [1:0]                    status;
  logic [caft_pkg::SLOT_W-1:0]   slot;
  logic                          last_hit;

  filter_scoreboard sb = new();

  // Each side switches now and then into a burst mode, in which it neither idles nor
  // stalls, so that back-to-back traffic is seen as well as gaps on every phase.
  bit send_burst = 1'b0;
  bit recv_burst = 1'b0;
  // Set once the random part starts, so that the long receiver hold-off lands in it.
  bit random_phase = 1'b0;

  can_acceptance_filter_table #(
    .FILTER_SLOTS(FILTER_SLOTS)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .opcode(opcode),
    .ident(ident),
    .id_mask(id_mask),
    .extended(extended),
    .slot_index(slot_index),
    .empty(empty),
    .pop(pop),
    .status(status),
    .slot(slot),
    .last_hit(last_hit)
  );

  always #5 clk = ~clk;

  // Offers one item and waits for the edge at which it is taken, then notes it in the
  // scoreboard. push is left high when no gap follows, so that the next item follows
  // directly without the valid being lowered and raised within one time step.
  task automatic send_cmd(input logic [1:0] op, input ident_t id, input ident_t msk,
                          input bit ext, input index_t idx);
    int unsigned gap;
    push <= 1'b1;
    opcode <= op;
    ident <= id;
    id_mask <= msk;
    extended <= ext;
    slot_index <= idx;
    do @(posedge clk); while (full);
    sb.note_item(op, id, msk, ext, idx);
    gap = send_burst ? 0 : $urandom_range(0, 7);
    if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Builds one random item. Most are well formed: valid filters, removes of real slots
  // and frames aimed at a live filter with only its unmasked bits disturbed. The rest
  // are invalid filters, out-of-range removes, stray frames and the unused opcode.
  // counted tells whether the block does anything with the item.
  task automatic send_random_cmd(output bit counted);
    int unsigned roll;
    int unsigned shape;
    int used;
    int s;
    logic [1:0] op;
    ident_t id;
    ident_t msk;
    bit ext;
    index_t idx;
    used = sb.used_slots();
    roll = $urandom_range(0, 99);
    id = ident_t'($urandom);
    msk = ident_t'($urandom);
    ext = 1'($urandom_range(0, 1));
    idx = index_t'($urandom_range(0, 15));
    if (roll < 4) begin
      op = OP_UNUSED;
    end else if (roll < (used >= 6 ? 40 : 20)) begin
      // Removes grow more frequent as the table fills, so it keeps cycling.
      op = caft_pkg::OP_REMOVE;
      if ($urandom_range(0, 4) != 0) idx = index_t'($urandom_range(0, FILTER_SLOTS - 1));
    end else if (roll < 55) begin
      op = caft_pkg::OP_ADD;
      shape = $urandom_range(0, 9);
      if (!ext) begin
        id = id & STD_LIMIT;
        msk = msk & STD_LIMIT;
      end
      if (shape == 2) msk = '0;
      if (shape == 3) msk = ext ? EXT_LIMIT : STD_LIMIT;
      // A standard filter with bits above the eleventh in the identifier or the mask.
      if (!ext && shape == 0) begin
        id = id | ident_t'($urandom_range(1, (1 << (caft_pkg::ID_W - caft_pkg::STD_ID_W)) - 1)
                           << caft_pkg::STD_ID_W);
      end
      if (!ext && shape == 1) begin
        msk = msk | ident_t'($urandom_range(1, (1 << (caft_pkg::ID_W - caft_pkg::STD_ID_W)) - 1)
                             << caft_pkg::STD_ID_W);
      end
    end else begin
      op = caft_pkg::OP_MATCH;
      if (used > 0 && $urandom_range(0, 3) != 0) begin
        s = sb.random_active_slot();
        ext = sb.filter_ext[s];
        id = sb.filter_ident[s] ^ (ident_t'($urandom) & ~sb.filter_mask[s]);
      end
    end
    counted = !(op == OP_UNUSED || (op == caft_pkg::OP_REMOVE && idx >= FILTER_SLOTS));
    send_cmd(op, id, msk, ext, idx);
  endtask

  // Sender: reset, the directed items, the random items and the drain at the end.
  initial begin
    int taken;
    bit counted;
    clk = 1'b0;
    rst = 1'b1;
    push = 1'b0;
    opcode = caft_pkg::OP_ADD;
    ident = '0;
    id_mask = '0;
    extended = 1'b0;
    slot_index = '0;
    pop = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Standard filter at the top of the 11-bit range, then the two
    // invalid forms, an extended filter at its extremes and two accept-all filters.
    send_cmd(caft_pkg::OP_ADD, STD_LIMIT, STD_LIMIT, 1'b0, '0);
    send_cmd(caft_pkg::OP_ADD, 29'h800, STD_LIMIT, 1'b0, '0);
    send_cmd(caft_pkg::OP_ADD, '0, 29'h800, 1'b0, '0);
    send_cmd(caft_pkg::OP_ADD, EXT_LIMIT, EXT_LIMIT, 1'b1, '0);
    send_cmd(caft_pkg::OP_ADD, '0, '0, 1'b1, '0);
    send_cmd(caft_pkg::OP_ADD, '0, '0, 1'b0, '0);
    // Frames: a standard one, a standard one with a wide identifier that is compared
    // as given, and extended ones that hit several slots or only the accept-all one.
    send_cmd(caft_pkg::OP_MATCH, STD_LIMIT, '0, 1'b0, '0);
    send_cmd(caft_pkg::OP_MATCH, EXT_LIMIT, '0, 1'b0, '0);
    send_cmd(caft_pkg::OP_MATCH, EXT_LIMIT, '0, 1'b1, '0);
    send_cmd(caft_pkg::OP_MATCH, '0, '0, 1'b1, '0);
    // Removing the accept-all extended filter leaves a frame that matches nothing.
    send_cmd(caft_pkg::OP_REMOVE, '0, '0, 1'b0, 4'd2);
    send_cmd(caft_pkg::OP_MATCH, '0, EXT_LIMIT, 1'b1, '0);
    // Out-of-range removes and the unused opcode leave the table alone.
    send_cmd(caft_pkg::OP_REMOVE, '0, '0, 1'b0, 4'd15);
    send_cmd(caft_pkg::OP_REMOVE, '0, '0, 1'b1, 4'd8);
    send_cmd(OP_UNUSED, EXT_LIMIT, EXT_LIMIT, 1'b1, 4'd15);
    send_cmd(caft_pkg::OP_REMOVE, '0, '0, 1'b0, 4'd0);
    send_cmd(caft_pkg::OP_REMOVE, '0, '0, 1'b0, 4'd1);
    // Fill every slot with a standard accept-all filter, overflow the table once and
    // then send a frame that every slot accepts, which gives the full eight hits.
    repeat (FILTER_SLOTS - 1) begin
      send_cmd(caft_pkg::OP_ADD, ident_t'($urandom) & STD_LIMIT, '0, 1'b0, '0);
    end
    send_cmd(caft_pkg::OP_ADD, STD_LIMIT, STD_LIMIT, 1'b0, '0);
    send_cmd(caft_pkg::OP_MATCH, '0, '0, 1'b0, '0);

    random_phase = 1'b1;
    taken = 0;
    while (taken < RANDOM_ITEMS) begin
      send_random_cmd(counted);
      if (counted) taken++;
    end
    push <= 1'b0;

    // Drain, then allow the engine's latency so that a stray late result is still caught.
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Receiver: takes result items with random stalls. Once in the random part it holds
  // off for a long stretch while the sender keeps offering, so the command queue fills
  // and full is seen.
  initial begin
    int unsigned gap;
    int results_taken;
    bit held_off;
    results_taken = 0;
    held_off = 1'b0;
    wait (rst === 1'b0);
    forever begin
      pop <= 1'b1;
      do @(posedge clk); while (empty);
      sb.check_result(status, slot, last_hit);
      results_taken++;
      gap = recv_burst ? 0 : $urandom_range(0, 7);
      if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
      if (random_phase && !held_off && results_taken >= 60) begin
        held_off = 1'b1;
        gap = HOLD_CYCLES;
      end
      if (gap != 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  end

  // Guard against a hung handshake: the slowest correct run is far below this.
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/caft_pkg.sv
design/caft_front.sv
design/caft_queue.sv
design/caft_back.sv
design/can_acceptance_filter_table.sv
design/caft_checker.sv
tb/testbench.sv
